// ===== hw/rtl/nddt_pkg.sv =====
// Package: types, character codes and automaton tables of the number/date-time lexer.
package nddt_pkg;

   localparam logic [5:0] DEAD_STATE  = 6'd0;
   localparam logic [5:0] START_STATE = 6'd1;
   localparam logic [5:0] NUM_STATES  = 6'd36;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_USC   = 8'h5F;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_LOW_E = 8'h65;
   localparam logic [7:0] CHAR_UP_E  = 8'h45;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_UP_T  = 8'h54;
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;

   typedef enum logic [3:0] {
      CLS_OTHER  = 4'd0,
      CLS_DIGIT  = 4'd1,
      CLS_USCORE = 4'd2,
      CLS_MINUS  = 4'd3,
      CLS_PLUS   = 4'd4,
      CLS_DOT    = 4'd5,
      CLS_EXP    = 4'd6,
      CLS_COLON  = 4'd7,
      CLS_TIME   = 4'd8,
      CLS_UTC    = 4'd9
   } char_class_type;

   typedef enum logic [1:0] {
      KIND_INVALID  = 2'd0,
      KIND_INTEGER  = 2'd1,
      KIND_FLOAT    = 2'd2,
      KIND_DATETIME = 2'd3
   } token_kind_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
      logic       start_req;
   } req_item_type;

   typedef struct packed {
      logic       keep_char;
      logic       done_res;
      logic [1:0] token_kind;
      logic [7:0] token_length;
   } rsp_item_type;

   typedef struct packed {
      logic [5:0]     dfa_state;
      token_kind_type match_kind;
      logic [7:0]     match_length;
      logic [7:0]     consumed_count;
   } scan_state_type;

   function automatic char_class_type char_class(input logic [7:0] c);
      char_class_type cls;
      cls = CLS_OTHER;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         cls = CLS_DIGIT;
      end else if (c == CHAR_USC) begin
         cls = CLS_USCORE;
      end else if (c == CHAR_MINUS) begin
         cls = CLS_MINUS;
      end else if (c == CHAR_PLUS) begin
         cls = CLS_PLUS;
      end else if (c == CHAR_DOT) begin
         cls = CLS_DOT;
      end else if (c == CHAR_LOW_E || c == CHAR_UP_E) begin
         cls = CLS_EXP;
      end else if (c == CHAR_COLON) begin
         cls = CLS_COLON;
      end else if (c == CHAR_UP_T) begin
         cls = CLS_TIME;
      end else if (c == CHAR_UP_Z) begin
         cls = CLS_UTC;
      end
      return cls;
   endfunction

   function automatic token_kind_type accept_kind(input logic [5:0] st);
      token_kind_type kind;
      unique case (st)
         6'd2, 6'd3, 6'd4, 6'd5, 6'd30:      kind = KIND_INTEGER;
         6'd32, 6'd35:                       kind = KIND_FLOAT;
         6'd11, 6'd17, 6'd20, 6'd22, 6'd28:  kind = KIND_DATETIME;
         default:                            kind = KIND_INVALID;
      endcase
      return kind;
   endfunction

   function automatic logic [5:0] dfa_next(input logic [5:0] st, input char_class_type cls);
      logic [5:0] nx;
      logic       sign;
      nx   = DEAD_STATE;
      sign = (cls == CLS_PLUS) || (cls == CLS_MINUS);
      unique case (st)
         6'd1: begin
            if (cls == CLS_DIGIT) nx = 6'd2;
            else if (sign)        nx = 6'd29;
         end
         6'd2, 6'd3, 6'd4, 6'd5, 6'd30: begin
            if (cls == CLS_DIGIT)       nx = (st == 6'd2 || st == 6'd3 || st == 6'd4) ?
                                             st + 6'd1 : st;
            else if (cls == CLS_USCORE) nx = 6'd29;
            else if (cls == CLS_DOT)    nx = 6'd31;
            else if (cls == CLS_EXP)    nx = 6'd33;
            else if (cls == CLS_MINUS && st == 6'd5) nx = 6'd6;
         end
         6'd6, 6'd7, 6'd9, 6'd10, 6'd12, 6'd13, 6'd15, 6'd16, 6'd18, 6'd19,
         6'd21, 6'd23, 6'd24, 6'd26, 6'd27, 6'd29, 6'd31: begin
            if (cls == CLS_DIGIT) nx = st + 6'd1;
         end
         6'd8: begin
            if (cls == CLS_MINUS) nx = 6'd9;
         end
         6'd14, 6'd25: begin
            if (cls == CLS_COLON) nx = st + 6'd1;
         end
         6'd11, 6'd17, 6'd20, 6'd22: begin
            if (cls == CLS_UTC)                      nx = 6'd28;
            else if (sign)                           nx = 6'd23;
            else if (cls == CLS_TIME && st == 6'd11)  nx = 6'd12;
            else if (cls == CLS_COLON && st == 6'd17) nx = 6'd18;
            else if (cls == CLS_DOT && st == 6'd20)   nx = 6'd21;
            else if (cls == CLS_DIGIT && st == 6'd22) nx = 6'd22;
         end
         6'd32: begin
            if (cls == CLS_DIGIT)       nx = 6'd32;
            else if (cls == CLS_USCORE) nx = 6'd31;
            else if (cls == CLS_EXP)    nx = 6'd33;
         end
         6'd33: begin
            if (sign)                  nx = 6'd34;
            else if (cls == CLS_DIGIT) nx = 6'd35;
         end
         6'd34: begin
            if (cls == CLS_DIGIT) nx = 6'd35;
         end
         6'd35: begin
            if (cls == CLS_DIGIT)       nx = 6'd35;
            else if (cls == CLS_USCORE) nx = 6'd34;
         end
         default: nx = DEAD_STATE;
      endcase
      return nx;
   endfunction

endpackage

// ===== hw/rtl/nddt_channels.sv =====
// Interfaces: request and response channels of the number/date-time lexer.
interface nddt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_text;
   logic       start_req;

   modport source(output valid, output char_code, output end_of_text, output start_req,
                  input ready);
   modport sink(input valid, input char_code, input end_of_text, input start_req,
                output ready);
endinterface

interface nddt_rsp_if;
   logic       valid;
   logic       ready;
   logic       keep_char;
   logic       done_res;
   logic [1:0] token_kind;
   logic [7:0] token_length;

   modport source(output valid, output keep_char, output done_res, output token_kind,
                  output token_length, input ready);
   modport sink(input valid, input keep_char, input done_res, input token_kind,
                input token_length, output ready);
endinterface

// ===== hw/rtl/number_datetime_token_lexer.sv =====
// Top level: longest-match lexer for integer, float and date-time literals.
//
// Usage:
//   req_chan carries one text byte per item (char_code), an end-of-text flag
//   and start_req, which begins a new scan from the start state with this
//   item's byte as the first byte. rsp_chan returns exactly one item per
//   request: keep_char marks a consumed non-underscore byte; done_res marks
//   the item that ended the scan, with token_kind and token_length of the
//   longest match seen.
//   An accepted request's result is registered in the two-entry result queue
//   and shown on rsp_chan once earlier results are taken. Throughput: one item
//   per cycle while the queue has a free entry; the automaton transition and
//   match bookkeeping form one combinational step from the scan registers.
//   Receiver stalls fill the queue; req_chan.ready drops only while both entries wait.
//   Reset (synchronous): the automaton is dead, match and length clear and
//   the queue empties; items seen while dead and without start_req return
//   all-zero results. Lengths saturate at min(MAX_TOKEN_LEN, 255).
module number_datetime_token_lexer #(
   parameter int unsigned MAX_TOKEN_LEN = 255
) (
   input  logic       clock,
   input  logic       reset,
   nddt_req_if.sink   req_chan,
   nddt_rsp_if.source rsp_chan
);
   import nddt_pkg::*;

   localparam int unsigned LenCapInt = (MAX_TOKEN_LEN < 255) ? MAX_TOKEN_LEN : 255;
   localparam logic [7:0]  LenCap    = 8'(LenCapInt);

   scan_state_type state_ff, state_in;
   scan_state_type step_state;
   req_item_type   req_item;
   rsp_item_type   rsp_item;
   logic           queue_not_full;
   logic           accept;

   // Take a byte whenever the result queue has a free entry.
   assign req_chan.ready = queue_not_full;
   assign accept         = req_chan.valid && req_chan.ready;

   assign req_item = '{char_code: req_chan.char_code, end_of_text: req_chan.end_of_text,
                       start_req: req_chan.start_req};

   nddt_step #(
      .LEN_CAP(LenCap)
   ) u_step (
      .cur_state(state_ff),
      .req_item (req_item),
      .nxt_state(step_state),
      .rsp_item (rsp_item)
   );

   // Advance the scan only on an accepted item; otherwise hold.
   assign state_in = accept ? step_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{dfa_state: DEAD_STATE, match_kind: KIND_INVALID,
                       match_length: 8'd0, consumed_count: 8'd0};
      end else begin
         state_ff <= state_in;
      end
   end

   nddt_out_queue u_out_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_item(rsp_item),
      .not_full (queue_not_full),
      .rsp_chan (rsp_chan)
   );

   a_state_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.dfa_state < NUM_STATES) else $error("automaton left its state range");
   a_done_kills: assert property (@(posedge clock) disable iff (reset)
      (accept && rsp_item.done_res) |=> (state_ff.dfa_state == DEAD_STATE))
      else $error("scan still alive after reporting done");
   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff.consumed_count <= LenCap) && (state_ff.match_length <= LenCap))
      else $error("length counter passed its cap");
   a_keep_vs_done: assert property (@(posedge clock) disable iff (reset)
      accept |-> !(rsp_item.keep_char && rsp_item.done_res))
      else $error("byte kept on the item that ended the scan");

endmodule

// ===== hw/rtl/nddt_step.sv =====
// Combinational step: classify one byte, record the match, take one transition.
module nddt_step #(
   parameter logic [7:0] LEN_CAP = 8'd255
) (
   input  nddt_pkg::scan_state_type cur_state,
   input  nddt_pkg::req_item_type   req_item,
   output nddt_pkg::scan_state_type nxt_state,
   output nddt_pkg::rsp_item_type   rsp_item
);
   import nddt_pkg::*;

   scan_state_type eff_state;
   token_kind_type acc_kind;
   char_class_type cls;
   logic [5:0]     nxt_dfa;
   logic           active;
   logic           done;

   always_comb begin
      eff_state = cur_state;
      if (req_item.start_req) begin
         eff_state = '{dfa_state: START_STATE, match_kind: KIND_INVALID,
                       match_length: 8'd0, consumed_count: 8'd0};
      end
      active   = (eff_state.dfa_state != DEAD_STATE) && (eff_state.dfa_state < NUM_STATES);
      acc_kind = accept_kind(eff_state.dfa_state);
      cls      = req_item.end_of_text ? CLS_OTHER : char_class(req_item.char_code);
      nxt_dfa  = dfa_next(eff_state.dfa_state, cls);
      done     = (nxt_dfa == DEAD_STATE);

      nxt_state = eff_state;
      rsp_item  = '0;
      if (active) begin
         if (acc_kind != KIND_INVALID) begin
            nxt_state.match_kind   = acc_kind;
            nxt_state.match_length = eff_state.consumed_count;
         end
         nxt_state.dfa_state = nxt_dfa;
         if (!done) begin
            rsp_item.keep_char = (req_item.char_code != CHAR_USC);
            if (eff_state.consumed_count < LEN_CAP) begin
               nxt_state.consumed_count = eff_state.consumed_count + 8'd1;
            end
         end else begin
            rsp_item.done_res     = 1'b1;
            rsp_item.token_kind   = nxt_state.match_kind;
            rsp_item.token_length = nxt_state.match_length;
         end
      end
   end

endmodule

// ===== hw/rtl/nddt_out_queue.sv =====
// Two-entry result queue that decouples the step logic from a stalled receiver.
module nddt_out_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  nddt_pkg::rsp_item_type push_item,
   output logic                   not_full,
   nddt_rsp_if.source             rsp_chan
);
   import nddt_pkg::*;

   rsp_item_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         pop;
   rsp_item_type head;

   assign not_full = (count_ff != 2'd2);
   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign head     = entry_ff[rd_ptr_ff];

   assign rsp_chan.valid        = (count_ff != 2'd0);
   assign rsp_chan.keep_char    = head.keep_char;
   assign rsp_chan.done_res     = head.done_res;
   assign rsp_chan.token_kind   = head.token_kind;
   assign rsp_chan.token_length = head.token_length;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("result queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd2 && !pop) |=> (count_ff == 2'd2))
      else $error("full queue lost an item without a pop");

endmodule
